@@ hw/rtl/sbat_pkg.sv @@
// Shared types, codes and sizes for the slotted bounded array table.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package sbat_pkg;

   localparam int NUM_SLOTS  = 10;
   localparam int SLOT_DEPTH = 16;

   localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int POS_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int FILL_W = $clog2(SLOT_DEPTH + 1);
   localparam int ADDR_W = (NUM_SLOTS * SLOT_DEPTH > 1) ? $clog2(NUM_SLOTS * SLOT_DEPTH) : 1;
   localparam int MEM_DEPTH = NUM_SLOTS * SLOT_DEPTH;
   localparam int SUM_W  = ((FILL_W > 7) ? FILL_W : 7) + 2;

   localparam int OP_W   = 3;
   localparam int SLOT_W = 4;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 7;
   localparam int STAT_W = 4;
   localparam int CNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 3'd0,
      OP_APPEND = 3'd1,
      OP_DROP   = 3'd2,
      OP_REMOVE = 3'd3,
      OP_RESIZE = 3'd4,
      OP_COUNT  = 3'd5,
      OP_READ   = 3'd6,
      OP_SORTED = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 4'd0,
      ST_BAD_SLOT  = 4'd1,
      ST_EXISTS    = 4'd2,
      ST_BAD_SIZE  = 4'd3,
      ST_NO_MEM    = 4'd4,
      ST_NO_SLOT   = 4'd5,
      ST_FULL      = 4'd6,
      ST_EMPTY     = 4'd7,
      ST_NOT_FOUND = 4'd8,
      ST_BAD_NEW   = 4'd9
   } status_type;

   // Classified command passed from front to back
   typedef struct packed {
      op_type                   op;
      logic                     slot_ok;
      logic [SIDX_W-1:0]        sidx;
      logic [ADDR_W-1:0]        base;
      logic signed [DATA_W-1:0] value;
      logic signed [SIZE_W-1:0] size_arg;
   } cmd_type;

endpackage

@@ hw/rtl/sbat_front.sv @@
// Front end: checks the slot number and forms the command for the queue.
// Depends on sbat_pkg.
`timescale 1ns / 1ps
module sbat_front (
   input  logic [2:0]         req_op,
   input  logic [3:0]         req_slot,
   input  logic signed [31:0] req_value,
   input  logic signed [6:0]  req_size_arg,
   output sbat_pkg::cmd_type  cmd
);
   import sbat_pkg::*;

   logic             ok;
   logic [SLOT_W-1:0] idx_full;

   // Classify slot number and compute its base address
   always_comb begin
      ok       = (req_slot >= SLOT_W'(1)) && (int'(req_slot) <= NUM_SLOTS);
      idx_full = req_slot - SLOT_W'(1);
      cmd.op       = op_type'(req_op);
      cmd.slot_ok  = ok;
      cmd.sidx     = ok ? SIDX_W'(idx_full) : '0;
      cmd.base     = ok ? ADDR_W'(SIDX_W'(idx_full)) * ADDR_W'(SLOT_DEPTH) : '0;
      cmd.value    = req_value;
      cmd.size_arg = req_size_arg;
   end

endmodule

@@ hw/rtl/sbat_queue.sv @@
// Two-entry command queue between front and back.
// Depends on sbat_pkg.
`timescale 1ns / 1ps
module sbat_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbat_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output sbat_pkg::cmd_type pop_data
);
   import sbat_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/sbat_back.sv @@
// Back end: slot bookkeeping, element memory, search/shift/read sequencer
// and the result register. Depends on sbat_pkg.
`timescale 1ns / 1ps
module sbat_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  sbat_pkg::cmd_type  q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic signed [31:0] rsp_data,
   output logic               rsp_data_valid,
   output logic               rsp_last
);
   import sbat_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_EXEC    = 12'b000000000010,
      S_SRCH_A  = 12'b000000000100,
      S_SRCH_D  = 12'b000000001000,
      S_SHIFT_A = 12'b000000010000,
      S_SHIFT_D = 12'b000000100000,
      S_RD_A    = 12'b000001000000,
      S_RD_D    = 12'b000010000000,
      S_SORT_A  = 12'b000100000000,
      S_SORT_D  = 12'b001000000000,
      S_SORT_E  = 12'b010000000000,
      S_DONE    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   logic              present_ff [NUM_SLOTS];
   logic [FILL_W-1:0] cap_ff     [NUM_SLOTS];
   logic [FILL_W-1:0] fill_ff    [NUM_SLOTS];

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [FILL_W-1:0] outcnt_ff, outcnt_in;
   logic              have_prev_ff, have_prev_in;
   logic              found_ff, found_in;
   logic [DATA_W+POS_W-1:0] prev_key_ff, prev_key_in;
   logic [DATA_W+POS_W-1:0] best_key_ff, best_key_in;
   logic [DATA_W-1:0] best_val_ff, best_val_in;
   status_type        pend_status_ff, pend_status_in;
   logic [FILL_W-1:0] pend_count_ff, pend_count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_dv_ff, rsp_dv_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              meta_we;
   logic              meta_present;
   logic [FILL_W-1:0] meta_cap;
   logic [FILL_W-1:0] meta_fill;

   logic              out_free;
   logic              cur_present;
   logic [FILL_W-1:0] cur_cap, cur_fill;
   logic [FILL_W:0]   idx_p1, idx_p2, out_p1;
   logic signed [SUM_W-1:0] sz_ext, new_cap;
   logic [DATA_W+POS_W-1:0] cand_key;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_data_valid = rsp_dv_ff;
   assign rsp_last       = rsp_last_ff;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cur_present = present_ff[cmd_ff.sidx];
   assign cur_cap     = cap_ff[cmd_ff.sidx];
   assign cur_fill    = fill_ff[cmd_ff.sidx];
   assign idx_p1      = (FILL_W+1)'(idx_ff) + (FILL_W+1)'(1);
   assign idx_p2      = (FILL_W+1)'(idx_ff) + (FILL_W+1)'(2);
   assign out_p1      = {1'b0, outcnt_ff} + (FILL_W+1)'(1);
   assign sz_ext      = SUM_W'(cmd_ff.size_arg);
   assign new_cap     = $signed(SUM_W'(cur_cap)) + sz_ext;
   assign cand_key    = {rdata_ff[DATA_W-1] ^ 1'b1, rdata_ff[DATA_W-2:0], idx_ff};
   assign rd_addr     = cmd_ff.base + ADDR_W'(idx_ff)
                        + ((state_ff == S_SHIFT_A || state_ff == S_SHIFT_D)
                           ? ADDR_W'(1) : ADDR_W'(0));

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      outcnt_in      = outcnt_ff;
      have_prev_in   = have_prev_ff;
      found_in       = found_ff;
      prev_key_in    = prev_key_ff;
      best_key_in    = best_key_ff;
      best_val_in    = best_val_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = cmd_ff.base + ADDR_W'(idx_ff);
      wr_data        = rdata_ff;
      meta_we        = 1'b0;
      meta_present   = cur_present;
      meta_cap       = cur_cap;
      meta_fill      = cur_fill;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_dv_in      = rsp_dv_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in       = S_DONE;
            pend_count_in  = cur_fill;
            pend_status_in = ST_OK;
            idx_in         = '0;
            if (!cmd_ff.slot_ok) begin
               pend_status_in = ST_BAD_SLOT;
               pend_count_in  = '0;
            end else if (cmd_ff.op == OP_CREATE) begin
               if (cur_present) begin
                  pend_status_in = ST_EXISTS;
               end else if (sz_ext < SUM_W'(1)) begin
                  pend_status_in = ST_BAD_SIZE;
               end else if (sz_ext > SUM_W'(SLOT_DEPTH)) begin
                  pend_status_in = ST_NO_MEM;
               end else begin
                  meta_we       = 1'b1;
                  meta_present  = 1'b1;
                  meta_cap      = FILL_W'(sz_ext);
                  meta_fill     = '0;
                  pend_count_in = '0;
               end
            end else if (!cur_present) begin
               pend_status_in = ST_NO_SLOT;
            end else begin
               case (cmd_ff.op)
                  OP_APPEND: begin
                     if (cur_fill >= cur_cap || int'(cur_fill) >= SLOT_DEPTH) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = cmd_ff.base + ADDR_W'(cur_fill);
                        wr_data       = cmd_ff.value;
                        meta_we       = 1'b1;
                        meta_fill     = cur_fill + FILL_W'(1);
                        pend_count_in = cur_fill + FILL_W'(1);
                     end
                  end
                  OP_DROP: begin
                     if (cur_fill == '0) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        meta_we       = 1'b1;
                        meta_fill     = cur_fill - FILL_W'(1);
                        pend_count_in = cur_fill - FILL_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (cur_fill == '0) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SRCH_A;
                     end
                  end
                  OP_RESIZE: begin
                     if (new_cap <= SUM_W'(0)) begin
                        pend_status_in = ST_BAD_NEW;
                     end else if (new_cap > SUM_W'(SLOT_DEPTH)) begin
                        pend_status_in = ST_NO_MEM;
                     end else begin
                        meta_we  = 1'b1;
                        meta_cap = FILL_W'(new_cap);
                        if (SUM_W'(cur_fill) > new_cap) begin
                           meta_fill     = FILL_W'(new_cap);
                           pend_count_in = FILL_W'(new_cap);
                        end
                     end
                  end
                  OP_COUNT: begin
                     if (cur_fill == '0) begin
                        pend_status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     // read and sorted read
                     if (cur_fill != '0) begin
                        have_prev_in = 1'b0;
                        found_in     = 1'b0;
                        outcnt_in    = '0;
                        state_in     = (cmd_ff.op == OP_SORTED) ? S_SORT_A : S_RD_A;
                     end
                  end
               endcase
            end
         end
         S_SRCH_A: state_in = S_SRCH_D;
         S_SRCH_D: begin
            if (rdata_ff == cmd_ff.value) begin
               pend_status_in = ST_OK;
               pend_count_in  = cur_fill - FILL_W'(1);
               if (idx_p1 < {1'b0, cur_fill}) begin
                  state_in = S_SHIFT_A;
               end else begin
                  meta_we   = 1'b1;
                  meta_fill = cur_fill - FILL_W'(1);
                  state_in  = S_DONE;
               end
            end else if (idx_p1 == {1'b0, cur_fill}) begin
               pend_status_in = ST_NOT_FOUND;
               pend_count_in  = cur_fill;
               state_in       = S_DONE;
            end else begin
               idx_in   = POS_W'(idx_p1);
               state_in = S_SRCH_A;
            end
         end
         S_SHIFT_A: state_in = S_SHIFT_D;
         S_SHIFT_D: begin
            // close the gap: w[idx] = w[idx + 1]
            wr_en = 1'b1;
            if (idx_p2 < {1'b0, cur_fill}) begin
               idx_in   = POS_W'(idx_p1);
               state_in = S_SHIFT_A;
            end else begin
               meta_we   = 1'b1;
               meta_fill = cur_fill - FILL_W'(1);
               state_in  = S_DONE;
            end
         end
         S_RD_A: state_in = S_RD_D;
         S_RD_D: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = CNT_W'(cur_fill);
               rsp_data_in   = rdata_ff;
               rsp_dv_in     = 1'b1;
               rsp_last_in   = (idx_p1 == {1'b0, cur_fill});
               if (idx_p1 == {1'b0, cur_fill}) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = POS_W'(idx_p1);
                  state_in = S_RD_A;
               end
            end
         end
         S_SORT_A: state_in = S_SORT_D;
         S_SORT_D: begin
            // keep the smallest (value, position) key above the last one sent
            if ((!have_prev_ff || cand_key > prev_key_ff)
                && (!found_ff || cand_key < best_key_ff)) begin
               found_in    = 1'b1;
               best_key_in = cand_key;
               best_val_in = rdata_ff;
            end
            if (idx_p1 == {1'b0, cur_fill}) begin
               state_in = S_SORT_E;
            end else begin
               idx_in   = POS_W'(idx_p1);
               state_in = S_SORT_A;
            end
         end
         S_SORT_E: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = CNT_W'(cur_fill);
               rsp_data_in   = best_val_ff;
               rsp_dv_in     = 1'b1;
               rsp_last_in   = (out_p1 == {1'b0, cur_fill});
               prev_key_in   = best_key_ff;
               have_prev_in  = 1'b1;
               found_in      = 1'b0;
               outcnt_in     = FILL_W'(out_p1);
               idx_in        = '0;
               state_in      = (out_p1 == {1'b0, cur_fill}) ? S_IDLE : S_SORT_A;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = CNT_W'(pend_count_ff);
               rsp_data_in   = '0;
               rsp_dv_in     = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            present_ff[i] <= 1'b0;
            cap_ff[i]     <= '0;
            fill_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (meta_we) begin
            present_ff[cmd_ff.sidx] <= meta_present;
            cap_ff[cmd_ff.sidx]     <= meta_cap;
            fill_ff[cmd_ff.sidx]    <= meta_fill;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      outcnt_ff      <= outcnt_in;
      have_prev_ff   <= have_prev_in;
      found_ff       <= found_in;
      prev_key_ff    <= prev_key_in;
      best_key_ff    <= best_key_in;
      best_val_ff    <= best_val_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_dv_ff      <= rsp_dv_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Element memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

endmodule

@@ hw/rtl/slotted_bounded_array_table_core.sv @@
// Top level of the slotted bounded array table: front, queue and back.
// Depends on sbat_pkg, sbat_front, sbat_queue and sbat_back.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | op, slot, value, size_arg
//   rsp     | out       | rsp_valid/rsp_ready | status, count, data, data_valid, last
//
// Remove searches the slot word by word, then moves each later word down one
// place; read sends the words in order; sorted read rescans the slot for
// every word. Each word searched, moved or read needs its own access to the
// element memory's single read port. Synchronous reset clears all slots;
// the queue holds two commands, so req stays ready until two commands wait
// behind a busy back end or a stalled rsp.
`timescale 1ns / 1ps
module slotted_bounded_array_table_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [3:0]         req_slot,
   input  logic signed [31:0] req_value,
   input  logic signed [6:0]  req_size_arg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic signed [31:0] rsp_data,
   output logic               rsp_data_valid,
   output logic               rsp_last
);
   import sbat_pkg::*;

   cmd_type front_cmd, q_cmd;
   logic    q_full, q_valid, q_pop;

   assign req_ready = !q_full;

   sbat_front u_front (
      .req_op       (req_op),
      .req_slot     (req_slot),
      .req_value    (req_value),
      .req_size_arg (req_size_arg),
      .cmd          (front_cmd)
   );

   sbat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_cmd)
   );

   sbat_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_data       (rsp_data),
      .rsp_data_valid (rsp_data_valid),
      .rsp_last       (rsp_last)
   );

endmodule

@@ tb/sv/slotted_bounded_array_table_core_tb.sv @@
// Testbench for the slotted bounded array table core: random and directed commands.
// Depends on sbat_pkg and slotted_bounded_array_table_core; holds its own table model.
`timescale 1ns / 1ps
module slotted_bounded_array_table_core_tb;
   import sbat_pkg::*;

   typedef struct {
      logic [3:0]  status;
      logic [4:0]  count;
      logic [31:0] data;
      logic        data_valid;
      logic        last;
   } table_rsp_type;

   // Table model and queue of expected responses
   class table_scoreboard;
      bit            present [NUM_SLOTS];
      int            capacity [NUM_SLOTS];
      int            fill [NUM_SLOTS];
      logic [31:0]   words [NUM_SLOTS][SLOT_DEPTH];
      table_rsp_type pending [$];
      int            errors;

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      function void push_rsp(status_type st, int cnt, logic [31:0] d, bit dv, bit lst);
         table_rsp_type r;
         r.status = st; r.count = cnt[4:0]; r.data = d; r.data_valid = dv; r.last = lst;
         pending.push_back(r);
      endfunction

      // Apply one accepted command to the table and queue its responses
      function void note_command(op_type op, logic [3:0] sn, logic [31:0] val,
                                 logic signed [6:0] sz);
         int s, f, at, nc, j;
         logic [31:0] buffer [SLOT_DEPTH];
         logic [31:0] t;
         if (sn < 1 || sn > NUM_SLOTS) begin
            push_rsp(ST_BAD_SLOT, 0, 0, 0, 1);
            return;
         end
         s = sn - 1;
         if (op == OP_CREATE) begin
            if (present[s]) push_rsp(ST_EXISTS, fill[s], 0, 0, 1);
            else if (sz < 1) push_rsp(ST_BAD_SIZE, fill[s], 0, 0, 1);
            else if (sz > SLOT_DEPTH) push_rsp(ST_NO_MEM, fill[s], 0, 0, 1);
            else begin
               present[s] = 1; capacity[s] = sz; fill[s] = 0;
               push_rsp(ST_OK, 0, 0, 0, 1);
            end
            return;
         end
         if (!present[s]) begin
            push_rsp(ST_NO_SLOT, fill[s], 0, 0, 1);
            return;
         end
         f = fill[s];
         case (op)
            OP_APPEND: begin
               if (f >= capacity[s]) push_rsp(ST_FULL, f, 0, 0, 1);
               else begin
                  words[s][f] = val; fill[s] = f + 1;
                  push_rsp(ST_OK, f + 1, 0, 0, 1);
               end
            end
            OP_DROP: begin
               if (f == 0) push_rsp(ST_EMPTY, 0, 0, 0, 1);
               else begin
                  fill[s] = f - 1; push_rsp(ST_OK, f - 1, 0, 0, 1);
               end
            end
            OP_REMOVE: begin
               if (f == 0) push_rsp(ST_EMPTY, 0, 0, 0, 1);
               else begin
                  at = f;
                  for (int i = 0; i < f; i++)
                     if (at == f && words[s][i] == val) at = i;
                  if (at == f) push_rsp(ST_NOT_FOUND, f, 0, 0, 1);
                  else begin
                     for (int i = at; i + 1 < f; i++) words[s][i] = words[s][i+1];
                     fill[s] = f - 1; push_rsp(ST_OK, f - 1, 0, 0, 1);
                  end
               end
            end
            OP_RESIZE: begin
               nc = capacity[s] + int'(sz);
               if (nc <= 0) push_rsp(ST_BAD_NEW, f, 0, 0, 1);
               else if (nc > SLOT_DEPTH) push_rsp(ST_NO_MEM, f, 0, 0, 1);
               else begin
                  capacity[s] = nc;
                  if (f > nc) f = nc;
                  fill[s] = f; push_rsp(ST_OK, f, 0, 0, 1);
               end
            end
            OP_COUNT: begin
               if (f == 0) push_rsp(ST_EMPTY, 0, 0, 0, 1);
               else push_rsp(ST_OK, f, 0, 0, 1);
            end
            default: begin
               if (f == 0) push_rsp(ST_OK, 0, 0, 0, 1);
               else begin
                  for (int i = 0; i < f; i++) buffer[i] = words[s][i];
                  // stable insertion sort by signed value
                  if (op == OP_SORTED)
                     for (int i = 1; i < f; i++) begin
                        t = buffer[i]; j = i;
                        while (j > 0 && $signed(buffer[j-1]) > $signed(t)) begin
                           buffer[j] = buffer[j-1]; j--;
                        end
                        buffer[j] = t;
                     end
                  for (int i = 0; i < f; i++)
                     push_rsp(ST_OK, f, buffer[i], 1, i + 1 == f);
               end
            end
         endcase
      endfunction

      // Compare one response with the oldest expectation
      task check_rsp(table_rsp_type got);
         table_rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
         if (got.count !== want.count)
            report_mismatch($sformatf("count %0d want %0d", got.count, want.count));
         if (got.data !== want.data)
            report_mismatch($sformatf("data %h want %h", got.data, want.data));
         if (got.data_valid !== want.data_valid)
            report_mismatch($sformatf("data_valid %b want %b", got.data_valid,
                                      want.data_valid));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b want %b", got.last, want.last));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_op;
   logic [3:0]         req_slot;
   logic signed [31:0] req_value;
   logic signed [6:0]  req_size_arg;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [3:0]         rsp_status;
   logic [4:0]         rsp_count;
   logic signed [31:0] rsp_data;
   logic               rsp_data_valid;
   logic               rsp_last;

   table_scoreboard board;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  cycle_count;
   logic [31:0] recent_words [8];

   slotted_bounded_array_table_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_slot(req_slot), .req_value(req_value),
      .req_size_arg(req_size_arg),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_count(rsp_count), .rsp_data(rsp_data),
      .rsp_data_valid(rsp_data_valid), .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Watchdog on total cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receive side: random stall, check each transfer
   always @(posedge clock) begin
      table_rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status; got.count = rsp_count; got.data = rsp_data;
         got.data_valid = rsp_data_valid; got.last = rsp_last;
         board.check_rsp(got);
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // Send one command, with a random gap first, and hold it until the transfer
   task automatic send_command(op_type op, logic [3:0] sn, logic [31:0] val,
                               logic signed [6:0] sz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_op <= op; req_slot <= sn;
      req_value <= val; req_size_arg <= sz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(op, sn, val, sz);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return recent_words[$urandom_range(7)];
         3: return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid slots and sizes that keep the table live
   task automatic send_random();
      op_type            op;
      logic [3:0]        sn;
      logic [31:0]       val;
      logic signed [6:0] sz;
      int                r;
      r = $urandom_range(99);
      if (r < 35) op = OP_APPEND;
      else op = op_type'($urandom_range(7));
      sn = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
      val = pick_word();
      if (op == OP_APPEND) recent_words[$urandom_range(7)] = val;
      if (op == OP_REMOVE && $urandom_range(2) != 0) val = recent_words[$urandom_range(7)];
      if ($urandom_range(7) == 0) sz = 7'($urandom);
      else if (op == OP_CREATE) sz = 7'($urandom_range(0, 17));
      else sz = $signed(7'($urandom_range(0, 12))) - 7'sd6;
      send_command(op, sn, val, sz);
   endtask

   task automatic run_phase(int n, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n) send_random();
   endtask

   initial begin
      int wait_cycles;
      board = new();
      for (int i = 0; i < 8; i++) recent_words[i] = $urandom;
      cycle_count = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_op = '0; req_slot = '0; req_value = '0; req_size_arg = '0;
      rsp_ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: invalid slots, create errors, full/empty, remove, resize, reads
      send_command(OP_APPEND, 4'd0, 32'd1, 7'sd0);
      send_command(OP_CREATE, 4'd15, 32'd0, 7'sd4);
      send_command(OP_COUNT, 4'd3, 32'd0, 7'sd0);
      send_command(OP_READ, 4'd3, 32'd0, 7'sd0);
      send_command(OP_CREATE, 4'd1, 32'd0, 7'sd0);
      send_command(OP_CREATE, 4'd1, 32'd0, -7'sd64);
      send_command(OP_CREATE, 4'd1, 32'd0, 7'sd17);
      send_command(OP_CREATE, 4'd1, 32'd0, 7'sd63);
      send_command(OP_CREATE, 4'd1, 32'd0, 7'sd3);
      send_command(OP_CREATE, 4'd1, 32'd0, 7'sd5);
      send_command(OP_CREATE, 4'd10, 32'hffff_ffff, 7'sd16);
      send_command(OP_DROP, 4'd1, 32'd0, 7'sd0);
      send_command(OP_REMOVE, 4'd1, 32'd0, 7'sd0);
      send_command(OP_COUNT, 4'd1, 32'd0, 7'sd0);
      send_command(OP_SORTED, 4'd1, 32'd0, 7'sd0);
      send_command(OP_APPEND, 4'd1, 32'h7fff_ffff, 7'sd0);
      send_command(OP_APPEND, 4'd1, 32'h8000_0000, 7'sd0);
      send_command(OP_APPEND, 4'd1, 32'h7fff_ffff, 7'sd0);
      send_command(OP_APPEND, 4'd1, 32'd5, 7'sd0);
      send_command(OP_SORTED, 4'd1, 32'd0, 7'sd0);
      send_command(OP_REMOVE, 4'd1, 32'h0000_0005, 7'sd0);
      send_command(OP_REMOVE, 4'd1, 32'h8000_0000, 7'sd0);
      send_command(OP_RESIZE, 4'd1, 32'd0, -7'sd3);
      send_command(OP_RESIZE, 4'd1, 32'd0, 7'sd14);
      send_command(OP_RESIZE, 4'd1, 32'd0, -7'sd2);
      send_command(OP_READ, 4'd1, 32'd0, 7'sd0);

      // Fill slot 10 to full depth and read it both ways
      for (int i = 0; i < 17; i++) send_command(OP_APPEND, 4'd10, $urandom, 7'sd0);
      send_command(OP_READ, 4'd10, 32'd0, 7'sd0);
      send_command(OP_SORTED, 4'd10, 32'd0, 7'sd0);

      run_phase(60, 19, 62);
      run_phase(60, 62, 19);
      run_phase(60, 0, 0);
      req_valid <= 1'b0;

      // Drain, then allow for trailing activity
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (600) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
